>>> design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RCPFA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RCPFA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rcpfa_pkg.sv
// types and constants of the page frame allocator
package rcpfa_pkg;

    localparam int FRAME_W         = 44;
    localparam int COUNT_OUT_W     = 16;
    localparam int DEF_NUM_FRAMES  = 32768;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [FRAME_W-1:0] POOL_BASE_RESET = 44'd524288;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_ADD   = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_EMPTY     = 3'd1,
        STATUS_OUTSIDE   = 3'd2,
        STATUS_ZERO      = 3'd3,
        STATUS_SATURATED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> design/rcpfa_req_if.sv
// request, response and configuration channels of the page frame allocator
interface rcpfa_req_if import rcpfa_pkg::*; ();
    logic               valid;
    logic               ready;
    kind_t              kind;
    logic [FRAME_W-1:0] frame_number;

    modport source (output valid, output kind, output frame_number, input ready);
    modport sink   (input valid, input kind, input frame_number, output ready);
endinterface

interface rcpfa_rsp_if import rcpfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [FRAME_W-1:0]     result_frame;
    logic [COUNT_OUT_W-1:0] count_after;
    logic                   returned_to_pool;

    modport source (output valid, output status, output result_frame,
                    output count_after, output returned_to_pool, input ready);
    modport sink   (input valid, input status, input result_frame,
                    input count_after, input returned_to_pool, output ready);
endinterface

interface rcpfa_cfg_if import rcpfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/rcpfa_ram.sv
// single write port, single read port synchronous ram with registered read
module rcpfa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/refcounted_page_frame_allocator.sv
// top level of the reference-counted page frame allocator
// In each request transaction the accept cycle issues the read of the free stack and count
// memories, the next cycle writes the modified entry back and loads the response
// register; that cycle repeats while the response register still holds an untaken
// transaction. One request is in flight at a time. After reset a clearing pass fills
// the free stack with ascending frame indices and zeroes all counts; no request is
// taken then, pool_base writes are.
module refcounted_page_frame_allocator import rcpfa_pkg::*; #(
    parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    rcpfa_cfg_if.sink   cfg,
    rcpfa_req_if.sink   req,
    rcpfa_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int FC_W  = $clog2(NUM_FRAMES + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [FC_W-1:0]        free_count_reg, free_count_next;
    logic [FRAME_W-1:0]     pool_base_reg;

    kind_t                  kind_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic                   in_pool_reg;
    logic [IDX_W-1:0]       idx_reg;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, res_status;
    logic [FRAME_W-1:0]     out_frame_reg, res_frame;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   out_returned_reg, res_returned;

    logic                   accept;
    logic                   exec_go;
    logic [FRAME_W-1:0]     off;
    logic                   in_pool;
    logic [FC_W-1:0]        fc_dec;

    logic                   stk_we, cnt_we;
    logic [IDX_W-1:0]       stk_wr_addr, stk_wr_data, cnt_wr_addr;
    logic [COUNT_WIDTH-1:0] cnt_wr_data;
    logic [IDX_W-1:0]       stk_rd_data;
    logic [COUNT_WIDTH-1:0] cnt_rd_data;
    logic [COUNT_WIDTH-1:0] cnt_dec;

    assign accept  = req.valid && req.ready;
    assign off     = req.frame_number - pool_base_reg;
    assign in_pool = (req.frame_number >= pool_base_reg) && (off < FRAME_W'(NUM_FRAMES));
    assign fc_dec  = free_count_reg - FC_W'(1);
    assign cnt_dec = cnt_rd_data - COUNT_ONE;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);

    rcpfa_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .clk     (clk),
        .we      (stk_we),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .re      (accept),
        .rd_addr (fc_dec[IDX_W-1:0]),
        .rd_data (stk_rd_data)
    );

    rcpfa_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (COUNT_WIDTH)
    ) u_count_ram (
        .clk     (clk),
        .we      (cnt_we),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .re      (accept),
        .rd_addr (off[IDX_W-1:0]),
        .rd_data (cnt_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_count_next = free_count_reg;
        exec_go         = 1'b0;
        stk_we          = 1'b0;
        stk_wr_addr     = clr_idx_reg;
        stk_wr_data     = clr_idx_reg;
        cnt_we          = 1'b0;
        cnt_wr_addr     = clr_idx_reg;
        cnt_wr_data     = '0;
        res_status      = STATUS_OK;
        res_frame       = frame_reg;
        res_count       = '0;
        res_returned    = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                stk_we       = 1'b1;
                cnt_we       = 1'b1;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(NUM_FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                exec_go = !out_valid_reg || rsp.ready;
                if (kind_reg == KIND_ALLOC)
                begin
                    if (free_count_reg == '0)
                    begin
                        res_status = STATUS_EMPTY;
                        res_frame  = '0;
                    end
                    else
                    begin
                        res_frame       = pool_base_reg + FRAME_W'(stk_rd_data);
                        res_count       = COUNT_ONE;
                        cnt_we          = exec_go;
                        cnt_wr_addr     = stk_rd_data;
                        cnt_wr_data     = COUNT_ONE;
                        free_count_next = exec_go ? fc_dec : free_count_reg;
                    end
                end
                else if (!in_pool_reg)
                begin
                    res_status = STATUS_OUTSIDE;
                end
                else
                begin
                    cnt_wr_addr = idx_reg;
                    case (kind_reg)
                        KIND_FREE:
                        begin
                            if (cnt_rd_data == '0)
                            begin
                                res_status = STATUS_ZERO;
                            end
                            else
                            begin
                                cnt_we      = exec_go;
                                cnt_wr_data = cnt_dec;
                                res_count   = cnt_dec;
                                if ((cnt_dec == '0) &&
                                    (free_count_reg < FC_W'(NUM_FRAMES)))
                                begin
                                    res_returned    = 1'b1;
                                    stk_we          = exec_go;
                                    stk_wr_addr     = free_count_reg[IDX_W-1:0];
                                    stk_wr_data     = idx_reg;
                                    free_count_next = exec_go ?
                                        free_count_reg + FC_W'(1) : free_count_reg;
                                end
                            end
                        end
                        KIND_ADD:
                        begin
                            if (cnt_rd_data == COUNT_MAX)
                            begin
                                res_status = STATUS_SATURATED;
                                res_count  = COUNT_MAX;
                            end
                            else
                            begin
                                cnt_we      = exec_go;
                                cnt_wr_data = cnt_rd_data + COUNT_ONE;
                                res_count   = cnt_rd_data + COUNT_ONE;
                            end
                        end
                        default:
                        begin
                            res_count = cnt_rd_data;
                        end
                    endcase
                end
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            free_count_reg <= FC_W'(NUM_FRAMES);
            pool_base_reg  <= POOL_BASE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                pool_base_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req.kind;
            frame_reg   <= req.frame_number;
            in_pool_reg <= in_pool;
            idx_reg     <= off[IDX_W-1:0];
        end
        if (exec_go)
        begin
            out_status_reg   <= res_status;
            out_frame_reg    <= res_frame;
            out_count_reg    <= COUNT_OUT_W'(res_count);
            out_returned_reg <= res_returned;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.result_frame     = out_frame_reg;
    assign rsp.count_after      = out_count_reg;
    assign rsp.returned_to_pool = out_returned_reg;

endmodule

>>> design/rcpfa_checker.sv
// port-level checker of the page frame allocator and its bind
`include "assert_macros.svh"

module rcpfa_checker import rcpfa_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [2:0]             rsp_status,
    input logic [FRAME_W-1:0]     rsp_result_frame,
    input logic [COUNT_OUT_W-1:0] rsp_count_after,
    input logic                   rsp_returned_to_pool
);

    `RCPFA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped before it was taken")
    `RCPFA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while another is in flight")
    `RCPFA_ASSERT_IMP(a_return_clean, clk, rst_n, rsp_valid && rsp_returned_to_pool, rsp_status == STATUS_OK && rsp_count_after == '0, "frame returned with nonzero count or bad status")
    `RCPFA_ASSERT_IMP(a_empty_clean, clk, rst_n, rsp_valid && rsp_status == STATUS_EMPTY, rsp_result_frame == '0 && rsp_count_after == '0 && !rsp_returned_to_pool, "empty pool response carries a frame")

endmodule

bind refcounted_page_frame_allocator rcpfa_checker u_rcpfa_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_result_frame     (rsp.result_frame),
    .rsp_count_after      (rsp.count_after),
    .rsp_returned_to_pool (rsp.returned_to_pool)
);

>>> test/refcounted_page_frame_allocator_tb.sv
// testbench for the reference-counted page frame allocator with a predictor and checker
module refcounted_page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpfa_pkg::*;

    localparam int NUM_FRAMES = DEF_NUM_FRAMES;
    localparam int COUNT_WIDTH = DEF_COUNT_WIDTH;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        status_t                status;
        logic [FRAME_W-1:0]     frame;
        logic [COUNT_OUT_W-1:0] count;
        logic                   returned;
    } page_result_t;

    logic clk;
    logic rst_n;

    rcpfa_cfg_if cfg_if();
    rcpfa_req_if req_if();
    rcpfa_rsp_if rsp_if();

    refcounted_page_frame_allocator #(
        .NUM_FRAMES(NUM_FRAMES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_if),
        .req(req_if),
        .rsp(rsp_if)
    );

    logic [FRAME_W-1:0] cur_pool_base;
    int unsigned        stack_idx [NUM_FRAMES];
    int unsigned        stack_depth;
    longint unsigned    frame_refs [NUM_FRAMES];
    int unsigned        recent_idx [$];
    page_result_t       pending_results [$];
    int                 err_cnt;
    int                 send_idle_pct;
    int                 rcv_stall_pct;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [FRAME_W-1:0] frame_at(longint unsigned idx);
        return cur_pool_base + FRAME_W'(idx);
    endfunction

    function automatic page_result_t predict_page_op(kind_t kind, logic [FRAME_W-1:0] fn);
        page_result_t       r;
        logic [FRAME_W-1:0] off;
        int unsigned        idx;
        r.status = STATUS_OK;
        r.frame = fn;
        r.count = '0;
        r.returned = 1'b0;
        off = fn - cur_pool_base;
        if (kind == KIND_ALLOC)
        begin
            r.frame = '0;
            if (stack_depth == 0)
            begin
                r.status = STATUS_EMPTY;
                return r;
            end
            stack_depth--;
            idx = stack_idx[stack_depth];
            frame_refs[idx] = 1;
            recent_idx.push_back(idx);
            if (recent_idx.size() > 64)
                void'(recent_idx.pop_front());
            r.frame = frame_at(idx);
            r.count = 1;
            return r;
        end
        // membership uses the unwrapped compare plus the modular offset
        if (fn < cur_pool_base || off >= NUM_FRAMES)
        begin
            r.status = STATUS_OUTSIDE;
            return r;
        end
        idx = int'(off);
        case (kind)
            KIND_FREE:
            begin
                if (frame_refs[idx] == 0)
                    r.status = STATUS_ZERO;
                else
                begin
                    frame_refs[idx]--;
                    if (frame_refs[idx] == 0 && stack_depth < NUM_FRAMES)
                    begin
                        stack_idx[stack_depth] = idx;
                        stack_depth++;
                        r.returned = 1'b1;
                    end
                    r.count = COUNT_OUT_W'(frame_refs[idx]);
                end
            end
            KIND_ADD:
            begin
                if (frame_refs[idx] >= COUNT_MAX)
                begin
                    frame_refs[idx] = COUNT_MAX;
                    r.status = STATUS_SATURATED;
                end
                else
                    frame_refs[idx]++;
                r.count = COUNT_OUT_W'(frame_refs[idx]);
            end
            default:
                r.count = COUNT_OUT_W'(frame_refs[idx]);
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        page_result_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $error("unexpected result: status %0d frame %0h", rsp_if.status,
                           rsp_if.result_frame);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("status", exp_r.status, rsp_if.status);
                check_field("result_frame", exp_r.frame, rsp_if.result_frame);
                check_field("count_after", exp_r.count, rsp_if.count_after);
                check_field("returned_to_pool", exp_r.returned, rsp_if.returned_to_pool);
            end
        end
    end

    always @(negedge clk)
        rsp_if.ready = ($urandom_range(99) >= rcv_stall_pct);

    task automatic send_page_op(input kind_t kind, input logic [FRAME_W-1:0] fn);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req_if.kind = kind;
        req_if.frame_number = fn;
        req_if.valid = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.push_back(predict_page_op(kind, fn));
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_pool_base(input logic [FRAME_W-1:0] value);
        wait_results_drained();
        cfg_if.data = value;
        cfg_if.valid = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cur_pool_base = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_random_op();
        kind_t              kind;
        logic [FRAME_W-1:0] fn;
        int unsigned        pick;
        pick = $urandom_range(99);
        kind = pick < 30 ? KIND_ALLOC : pick < 62 ? KIND_FREE : pick < 87 ? KIND_ADD : KIND_QUERY;
        pick = $urandom_range(99);
        fn = FRAME_W'({$urandom(), $urandom()});
        if (pick < 60 && recent_idx.size() != 0)
            fn = frame_at(recent_idx[$urandom_range(recent_idx.size() - 1)]);
        else if (pick < 75)
            fn = frame_at($urandom_range(NUM_FRAMES - 1));
        else if (pick < 85)
        begin
            case ($urandom_range(3))
                0: fn = cur_pool_base - 1;
                1: fn = cur_pool_base;
                2: fn = frame_at(NUM_FRAMES - 1);
                default: fn = frame_at(NUM_FRAMES);
            endcase
        end
        send_page_op(kind, fn);
    endtask

    task automatic test_basic_ops();
        logic [FRAME_W-1:0] top;
        top = frame_at(NUM_FRAMES - 1);
        // free of a never-allocated frame while the stack is full does not push
        send_page_op(KIND_ADD, frame_at(5));
        send_page_op(KIND_FREE, frame_at(5));
        send_page_op(KIND_ALLOC, '0);
        send_page_op(KIND_ALLOC, FRAME_MAX);
        send_page_op(KIND_QUERY, top);
        send_page_op(KIND_ADD, top);
        send_page_op(KIND_FREE, top);
        send_page_op(KIND_FREE, top);
        send_page_op(KIND_FREE, top);
        send_page_op(KIND_ALLOC, FRAME_MAX);
        send_page_op(KIND_QUERY, frame_at(5));
        send_page_op(KIND_FREE, cur_pool_base - 1);
        send_page_op(KIND_ADD, frame_at(NUM_FRAMES));
        send_page_op(KIND_FREE, frame_at(0));
        send_page_op(KIND_QUERY, '0);
        send_page_op(KIND_ADD, FRAME_MAX);
    endtask

    task automatic test_pool_base_extremes();
        write_pool_base('0);
        send_page_op(KIND_ALLOC, '0);
        send_page_op(KIND_QUERY, frame_at(0));
        send_page_op(KIND_ADD, frame_at(NUM_FRAMES));
        write_pool_base(FRAME_MAX);
        // allocated frames wrap past the top and then fall outside the pool
        send_page_op(KIND_ALLOC, '0);
        send_page_op(KIND_QUERY, FRAME_MAX);
        send_page_op(KIND_FREE, frame_at(1));
        send_page_op(KIND_ADD, FRAME_MAX - 1);
        write_pool_base(FRAME_MAX - 15);
        send_page_op(KIND_ALLOC, '0);
        send_page_op(KIND_ADD, frame_at(20));
        send_page_op(KIND_QUERY, frame_at(15));
    endtask

    task automatic test_count_saturation();
        logic [FRAME_W-1:0] fn;
        write_pool_base(POOL_BASE_RESET);
        send_page_op(KIND_ALLOC, '0);
        fn = frame_at(recent_idx[$]);
        repeat (COUNT_MAX - 1)
            send_page_op(KIND_ADD, fn);
        repeat (2)
            send_page_op(KIND_ADD, fn);
        send_page_op(KIND_FREE, fn);
        send_page_op(KIND_QUERY, fn);
    endtask

    task automatic test_pool_exhaustion();
        while (stack_depth != 0)
            send_page_op(KIND_ALLOC, FRAME_W'({$urandom(), $urandom()}));
        repeat (3)
            send_page_op(KIND_ALLOC, '0);
        send_page_op(KIND_FREE, frame_at(recent_idx[$]));
        send_page_op(KIND_ALLOC, '0);
    endtask

    task automatic test_random_traffic(input logic [FRAME_W-1:0] base, input int idle_pct,
                                       input int stall_pct, input int items);
        write_pool_base(base);
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
        repeat (items)
        begin
            if ($urandom_range(199) == 0)
                wait_results_drained();
            send_random_op();
        end
        wait_results_drained();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        req_if.valid = 1'b0;
        req_if.kind = KIND_ALLOC;
        req_if.frame_number = '0;
        rsp_if.ready = 1'b1;
        err_cnt = 0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        cur_pool_base = POOL_BASE_RESET;
        stack_depth = NUM_FRAMES;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            stack_idx[i] = i;
            frame_refs[i] = 0;
        end
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_pool_base_extremes();
        test_count_saturation();
        test_pool_exhaustion();
        test_random_traffic(FRAME_W'({$urandom(), $urandom()}), 18, 78, RANDOM_ITEMS / 3);
        test_random_traffic(FRAME_MAX - 20000, 78, 18, RANDOM_ITEMS / 3);
        test_random_traffic(POOL_BASE_RESET, 0, 0, RANDOM_ITEMS / 3);

        wait_results_drained();
        repeat (20)
            @(negedge clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("refcounted_page_frame_allocator_tb: done, clean");
        else
            $display("refcounted_page_frame_allocator_tb: done, errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("refcounted_page_frame_allocator_tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/rcpfa_pkg.sv
design/rcpfa_req_if.sv
design/rcpfa_ram.sv
design/refcounted_page_frame_allocator.sv
design/rcpfa_checker.sv
test/refcounted_page_frame_allocator_tb.sv
